/* hw/rtl/rv64i_subset_execute_core_assert.svh */
// assertion helpers shared by the execute core rtl
`ifndef RV64I_SUBSET_EXECUTE_CORE_ASSERT_SVH
`define RV64I_SUBSET_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RVSEC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RVSEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rvsec_pkg.sv */
`default_nettype none
package rvsec_pkg;

    localparam logic [6:0] OP_R      = 7'b0110011;
    localparam logic [6:0] OP_I      = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;

    localparam logic [6:0] F7_ALT       = 7'h20;
    localparam logic [5:0] F6_SRA       = 6'h10;
    localparam logic [31:0] MEM_BASE_RST = 32'h0001_0000;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_LWU  = 3'd6;
    // reserved encodings, and the only funct3 that JALR accepts
    localparam logic [2:0] F3_LD_RSV   = 3'd7;
    localparam logic [2:0] F3_BR_RSV_A = 3'd2;
    localparam logic [2:0] F3_BR_RSV_B = 3'd3;
    localparam logic [2:0] F3_JALR0    = 3'd0;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        wr;
        logic [4:0]  rd;
        logic [63:0] val;
        logic        taken;
        status_t     status;
        logic        ld_go;
        logic        st_go;
        logic [2:0]  funct3;
        logic [7:0]  byte_mask;
    } ex_res_t;

endpackage
`default_nettype wire

/* hw/rtl/rv64i_subset_execute_core.sv */
// channel  | dir | width | contents
// s_       | in  | 32    | tdata: instr
// m_       | out | 208   | tdata: exec_pc, next_pc, reg_written, reg_index, reg_value,
//          |     |       |        branch_taken, status, zero pad
// cfg_     | in  | 32    | mem_base write
// one instruction per cycle while nothing stalls; a load adds the registered data memory read
// that follows the execute stage, and the s_ side waits until that load can retire
// after reset the data memory is zeroed row by row, and s_tready stays low meanwhile
// a stalled m_ side holds the execute stage, but for a load moving on to the memory read, and with it the s_ side
`default_nettype none
module rv64i_subset_execute_core #(
    parameter int MEM_BYTES = 262144
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] instr
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [63:0] exec_pc, [127:64] next_pc, [128] reg_written, [133:129] reg_index,
    // [197:134] reg_value, [198] branch_taken, [200:199] status, [207:201] zero
    output logic [207:0]      m_tdata,
    input  wire logic         cfg_wen,
    input  wire logic [31:0]  cfg_wdata
);

    `include "rv64i_subset_execute_core_assert.svh"

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = (MEM_BYTES + 7) / 8;
    localparam int RW   = $clog2(ROWS);

    logic [31:0]        mem_base_reg;
    logic               clr_busy_reg;
    logic [RW-1:0]      clr_row_reg;
    logic [63:0]        pc_reg;

    logic               ex_valid_reg;
    logic [31:0]        ex_instr_reg;
    logic [63:0]        ex_pc_reg;

    logic               mem_valid_reg;
    logic [63:0]        mem_pc_reg;
    logic [4:0]         mem_rd_reg;
    logic [2:0]         mem_f3_reg;

    logic               m_valid_reg;
    logic [63:0]        out_epc_reg;
    logic [63:0]        out_npc_reg;
    logic               out_wr_reg;
    logic [4:0]         out_idx_reg;
    logic [63:0]        out_val_reg;
    logic               out_taken_reg;
    rvsec_pkg::status_t out_status_reg;

    logic               s_accept;
    logic               out_free;
    logic               mem_adv;
    logic               ex_adv;
    logic               ex_to_out;
    logic               ex_to_mem;
    logic [63:0]        new_pc;
    logic [63:0]        rs1_val;
    logic [63:0]        rs2_val;
    rvsec_pkg::ex_res_t ex_res;
    logic [AW-1:0]      ex_off;
    logic [63:0]        ld_raw;
    logic [63:0]        ld_val;
    logic               mem_wr;
    logic               rf_we;
    logic [4:0]         rf_wa;
    logic [63:0]        rf_wd;

    assign out_free  = !m_valid_reg || m_tready;
    assign mem_adv   = mem_valid_reg && out_free;
    assign ex_adv    = ex_valid_reg && (ex_res.ld_go || out_free);
    assign ex_to_out = ex_adv && !ex_res.ld_go;
    assign ex_to_mem = ex_adv && ex_res.ld_go;

    // a load in flight blocks the next transfer until its writeback can be bypassed
    assign s_tready = !clr_busy_reg && (!ex_valid_reg || ex_to_out) &&
                      (!mem_valid_reg || mem_adv);
    assign s_accept = s_tvalid && s_tready;
    assign new_pc   = ex_valid_reg ? ex_res.next_pc : pc_reg;

    assign mem_wr = mem_rd_reg != 5'd0;
    assign rf_we  = (mem_adv && mem_wr) || (ex_to_out && ex_res.wr);
    assign rf_wa  = mem_adv ? mem_rd_reg : ex_res.rd;
    assign rf_wd  = mem_adv ? ld_val : ex_res.val;

    rvsec_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rs1_addr (s_tdata[19:15]),
        .rs2_addr (s_tdata[24:20]),
        .we       (rf_we),
        .waddr    (rf_wa),
        .wdata    (rf_wd),
        .rs1_data (rs1_val),
        .rs2_data (rs2_val)
    );

    rvsec_exec #(
        .MEM_BYTES (MEM_BYTES)
    ) u_exec (
        .instr    (ex_instr_reg),
        .pc       (ex_pc_reg),
        .rs1_val  (rs1_val),
        .rs2_val  (rs2_val),
        .mem_base (mem_base_reg),
        .res      (ex_res),
        .mem_off  (ex_off)
    );

    rvsec_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .aclk      (aclk),
        .wr_en     (ex_adv && ex_res.st_go),
        .rd_en     (ex_to_mem),
        .off       (ex_off),
        .byte_mask (ex_res.byte_mask),
        .wdata     (rs2_val),
        .clr_en    (clr_busy_reg),
        .clr_row   (clr_row_reg),
        .rdata     (ld_raw)
    );

    always_comb begin
        case (mem_f3_reg)
            rvsec_pkg::F3_LB:  ld_val = {{56{ld_raw[7]}}, ld_raw[7:0]};
            rvsec_pkg::F3_LH:  ld_val = {{48{ld_raw[15]}}, ld_raw[15:0]};
            rvsec_pkg::F3_LW:  ld_val = {{32{ld_raw[31]}}, ld_raw[31:0]};
            rvsec_pkg::F3_LD:  ld_val = ld_raw;
            rvsec_pkg::F3_LBU: ld_val = {56'd0, ld_raw[7:0]};
            rvsec_pkg::F3_LHU: ld_val = {48'd0, ld_raw[15:0]};
            rvsec_pkg::F3_LWU: ld_val = {32'd0, ld_raw[31:0]};
            default:           ld_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_base_reg  <= rvsec_pkg::MEM_BASE_RST;
            clr_busy_reg  <= 1'b1;
            clr_row_reg   <= '0;
            pc_reg        <= '0;
            ex_valid_reg  <= 1'b0;
            mem_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wen) begin
                mem_base_reg <= cfg_wdata;
            end
            if (clr_busy_reg) begin
                clr_row_reg <= clr_row_reg + RW'(1);
                if (clr_row_reg == RW'(ROWS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (ex_adv) begin
                pc_reg <= ex_res.next_pc;
            end
            if (s_accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_adv) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_to_mem) begin
                mem_valid_reg <= 1'b1;
            end else if (mem_adv) begin
                mem_valid_reg <= 1'b0;
            end
            if (mem_adv || ex_to_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_instr_reg <= s_tdata;
            ex_pc_reg    <= new_pc;
        end
        if (ex_to_mem) begin
            mem_pc_reg <= ex_pc_reg;
            mem_rd_reg <= ex_res.rd;
            mem_f3_reg <= ex_res.funct3;
        end
        if (mem_adv) begin
            out_epc_reg    <= mem_pc_reg;
            out_npc_reg    <= mem_pc_reg + 64'd4;
            out_wr_reg     <= mem_wr;
            out_idx_reg    <= mem_rd_reg;
            out_val_reg    <= mem_wr ? ld_val : 64'd0;
            out_taken_reg  <= 1'b0;
            out_status_reg <= rvsec_pkg::ST_OK;
        end else if (ex_to_out) begin
            out_epc_reg    <= ex_pc_reg;
            out_npc_reg    <= ex_res.next_pc;
            out_wr_reg     <= ex_res.wr;
            out_idx_reg    <= ex_res.wr ? ex_res.rd : 5'd0;
            out_val_reg    <= ex_res.val;
            out_taken_reg  <= ex_res.taken;
            out_status_reg <= ex_res.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_taken_reg, out_val_reg, out_idx_reg,
                       out_wr_reg, out_npc_reg, out_epc_reg};

    `RVSEC_ASSERT_NOW(a_no_transfer_in_clear, aclk, aresetn,
        clr_busy_reg, !s_tready, "input taken during memory clear")
    `RVSEC_ASSERT_NOW(a_no_x0_write, aclk, aresetn,
        rf_we, rf_wa != 5'd0, "register write aimed at x0")
    `RVSEC_ASSERT_NOW(a_one_writeback, aclk, aresetn,
        mem_adv, !ex_to_out, "execute and load stages retire together")
    `RVSEC_ASSERT_NEXT(a_load_follows, aclk, aresetn,
        ex_to_mem, mem_valid_reg && !ex_valid_reg, "load stage not loaded in order")

endmodule
`default_nettype wire

/* hw/rtl/rvsec_regfile.sv */
`default_nettype none
module rvsec_regfile (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        rd_en,
    input  wire logic [4:0]  rs1_addr,
    input  wire logic [4:0]  rs2_addr,
    input  wire logic        we,
    input  wire logic [4:0]  waddr,
    input  wire logic [63:0] wdata,
    output logic      [63:0] rs1_data,
    output logic      [63:0] rs2_data
);

    logic [63:0] rf_mem [32];
    logic [31:0] vld_reg;
    logic [63:0] rs1_data_reg;
    logic [63:0] rs2_data_reg;

    // entries never written read as zero, x0 is never written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            rf_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            // bypass the write landing in the same cycle
            if (we && waddr == rs1_addr) begin
                rs1_data_reg <= wdata;
            end else begin
                rs1_data_reg <= vld_reg[rs1_addr] ? rf_mem[rs1_addr] : 64'd0;
            end
            if (we && waddr == rs2_addr) begin
                rs2_data_reg <= wdata;
            end else begin
                rs2_data_reg <= vld_reg[rs2_addr] ? rf_mem[rs2_addr] : 64'd0;
            end
        end
    end

    assign rs1_data = rs1_data_reg;
    assign rs2_data = rs2_data_reg;

endmodule
`default_nettype wire

/* hw/rtl/rvsec_exec.sv */
`default_nettype none
module rvsec_exec #(
    parameter int MEM_BYTES = 262144
) (
    input  wire logic [31:0]             instr,
    input  wire logic [63:0]             pc,
    input  wire logic [63:0]             rs1_val,
    input  wire logic [63:0]             rs2_val,
    input  wire logic [31:0]             mem_base,
    output rvsec_pkg::ex_res_t           res,
    output logic [$clog2(MEM_BYTES)-1:0] mem_off
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [63:0] imm_i;
    logic [63:0] imm_s;
    logic [63:0] imm_b;
    logic [63:0] imm_j;
    logic [63:0] imm_u;
    logic [63:0] pc_plus4;
    logic [63:0] operand;
    logic [5:0]  shamt;
    logic [63:0] alu_val;
    logic        alu_ok;
    logic        bad_ri;
    logic [63:0] eff_addr;
    logic [63:0] off64;
    logic [3:0]  nbytes;
    logic [7:0]  bmask;
    logic        in_range;
    logic        cond;

    assign opcode   = instr[6:0];
    assign rd       = instr[11:7];
    assign f3       = instr[14:12];
    assign f7       = instr[31:25];
    assign imm_i    = {{52{instr[31]}}, instr[31:20]};
    assign imm_s    = {{52{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b    = {{52{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j    = {{44{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
    assign imm_u    = {{32{instr[31]}}, instr[31:12], 12'd0};
    assign pc_plus4 = pc + 64'd4;

    assign operand = (opcode == rvsec_pkg::OP_R) ? rs2_val : imm_i;
    assign shamt   = operand[5:0];

    always_comb begin
        bad_ri = 1'b0;
        if (opcode == rvsec_pkg::OP_R) begin
            bad_ri = (f7 != 7'd0) &&
                     !(f7 == rvsec_pkg::F7_ALT &&
                       (f3 == rvsec_pkg::F3_ADD || f3 == rvsec_pkg::F3_SR));
        end else begin
            if (f3 == rvsec_pkg::F3_SLL && instr[31:26] != 6'd0) begin
                bad_ri = 1'b1;
            end
            if (f3 == rvsec_pkg::F3_SR && instr[31:26] != 6'd0 &&
                instr[31:26] != rvsec_pkg::F6_SRA) begin
                bad_ri = 1'b1;
            end
        end
    end

    always_comb begin
        alu_ok  = 1'b1;
        alu_val = '0;
        case (f3)
            rvsec_pkg::F3_ADD: begin
                if (opcode == rvsec_pkg::OP_R && f7 == rvsec_pkg::F7_ALT) begin
                    alu_val = rs1_val - operand;
                end else begin
                    alu_val = rs1_val + operand;
                end
            end
            rvsec_pkg::F3_SLL: alu_val = rs1_val << shamt;
            rvsec_pkg::F3_XOR: alu_val = rs1_val ^ operand;
            rvsec_pkg::F3_SR: begin
                if (instr[30]) begin
                    alu_val = $unsigned($signed(rs1_val) >>> shamt);
                end else begin
                    alu_val = rs1_val >> shamt;
                end
            end
            rvsec_pkg::F3_OR:  alu_val = rs1_val | operand;
            rvsec_pkg::F3_AND: alu_val = rs1_val & operand;
            default:           alu_ok  = 1'b0;
        endcase
    end

    // data access window check
    always_comb begin
        case (f3[1:0])
            2'd0:    begin nbytes = 4'd1; bmask = 8'h01; end
            2'd1:    begin nbytes = 4'd2; bmask = 8'h03; end
            2'd2:    begin nbytes = 4'd4; bmask = 8'h0f; end
            default: begin nbytes = 4'd8; bmask = 8'hff; end
        endcase
    end

    assign eff_addr = rs1_val + ((opcode == rvsec_pkg::OP_STORE) ? imm_s : imm_i);
    assign off64    = eff_addr - {32'd0, mem_base};
    assign in_range = (off64 < 64'(MEM_BYTES)) &&
                      ((off64 + {60'd0, nbytes}) <= 64'(MEM_BYTES));
    assign mem_off  = off64[AW-1:0];

    always_comb begin
        case (f3)
            rvsec_pkg::F3_BEQ:  cond = rs1_val == rs2_val;
            rvsec_pkg::F3_BNE:  cond = rs1_val != rs2_val;
            rvsec_pkg::F3_BLT:  cond = $signed(rs1_val) < $signed(rs2_val);
            rvsec_pkg::F3_BGE:  cond = $signed(rs1_val) >= $signed(rs2_val);
            rvsec_pkg::F3_BLTU: cond = rs1_val < rs2_val;
            rvsec_pkg::F3_BGEU: cond = rs1_val >= rs2_val;
            default:            cond = 1'b0;
        endcase
    end

    always_comb begin
        res           = '0;
        res.next_pc   = pc_plus4;
        res.rd        = rd;
        res.status    = rvsec_pkg::ST_OK;
        res.funct3    = f3;
        res.byte_mask = bmask;
        case (opcode)
            rvsec_pkg::OP_R, rvsec_pkg::OP_I: begin
                if (bad_ri || !alu_ok) begin
                    res.status = rvsec_pkg::ST_UNSUP;
                end else begin
                    res.wr  = 1'b1;
                    res.val = alu_val;
                end
            end
            rvsec_pkg::OP_LOAD: begin
                if (f3 == rvsec_pkg::F3_LD_RSV) begin
                    res.status = rvsec_pkg::ST_UNSUP;
                end else if (!in_range) begin
                    res.status = rvsec_pkg::ST_RANGE;
                end else begin
                    res.ld_go = 1'b1;
                end
            end
            rvsec_pkg::OP_STORE: begin
                if (f3[2]) begin
                    res.status = rvsec_pkg::ST_UNSUP;
                end else if (!in_range) begin
                    res.status = rvsec_pkg::ST_RANGE;
                end else begin
                    res.st_go = 1'b1;
                end
            end
            rvsec_pkg::OP_BRANCH: begin
                if (f3 inside {rvsec_pkg::F3_BR_RSV_A, rvsec_pkg::F3_BR_RSV_B}) begin
                    res.status = rvsec_pkg::ST_UNSUP;
                end else if (cond) begin
                    res.taken   = 1'b1;
                    res.next_pc = pc + imm_b;
                end
            end
            rvsec_pkg::OP_JAL: begin
                res.wr      = 1'b1;
                res.val     = pc_plus4;
                res.taken   = 1'b1;
                res.next_pc = pc + imm_j;
            end
            rvsec_pkg::OP_JALR: begin
                if (f3 != rvsec_pkg::F3_JALR0) begin
                    res.status = rvsec_pkg::ST_UNSUP;
                end else begin
                    res.wr      = 1'b1;
                    res.val     = pc_plus4;
                    res.taken   = 1'b1;
                    res.next_pc = (rs1_val + imm_i) & ~64'd1;
                end
            end
            rvsec_pkg::OP_LUI: begin
                res.wr  = 1'b1;
                res.val = imm_u;
            end
            default: res.status = rvsec_pkg::ST_UNSUP;
        endcase
        if (rd == 5'd0) begin
            res.wr = 1'b0;
        end
        if (!res.wr) begin
            res.val = '0;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rvsec_dmem.sv */
`default_nettype none
module rvsec_dmem #(
    parameter int MEM_BYTES = 262144
) (
    input  wire logic                              aclk,
    input  wire logic                              wr_en,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(MEM_BYTES)-1:0]      off,
    input  wire logic [7:0]                        byte_mask,
    input  wire logic [63:0]                       wdata,
    input  wire logic                              clr_en,
    input  wire logic [$clog2((MEM_BYTES+7)/8)-1:0] clr_row,
    output logic      [63:0]                       rdata
);

    localparam int ROWS = (MEM_BYTES + 7) / 8;
    localparam int RW   = $clog2(ROWS);

    logic [2:0]      lo;
    logic [2:0]      lo_reg;
    logic [RW-1:0]   row0;
    logic [7:0][7:0] rd_bytes;

    assign lo   = off[2:0];
    assign row0 = RW'(off >> 3);

    // eight byte banks, byte i of an access lands in bank (off + i) mod 8
    for (genvar k = 0; k < 8; k++) begin : g_bank
        logic [7:0]    bank_mem [ROWS];
        logic [2:0]    pos;
        logic [RW-1:0] row;
        logic          bank_we;
        logic [7:0]    wbyte;
        logic [7:0]    byte_rd_reg;

        assign pos     = 3'(k) - lo;
        assign row     = clr_en ? clr_row : row0 + RW'(3'(k) < lo);
        assign bank_we = clr_en || (wr_en && byte_mask[pos]);
        assign wbyte   = clr_en ? 8'h00 : wdata[{pos, 3'b000} +: 8];

        always_ff @(posedge aclk) begin
            if (bank_we) begin
                bank_mem[row] <= wbyte;
            end
            if (rd_en) begin
                byte_rd_reg <= bank_mem[row];
            end
        end

        assign rd_bytes[k] = byte_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            lo_reg <= lo;
        end
    end

    for (genvar i = 0; i < 8; i++) begin : g_rot
        logic [2:0] sel;
        assign sel             = 3'(i) + lo_reg;
        assign rdata[8*i +: 8] = rd_bytes[sel];
    end

endmodule
`default_nettype wire

/* dv/tb_rv64i_subset_execute_core.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_rv64i_subset_execute_core;
    import rvsec_pkg::*;

    localparam int MEM_BYTES = 262144;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SD = 3'd3;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_BBAD = 3'd2;
    localparam logic [2:0] F3_LBAD = 3'd7;
    localparam logic [2:0] F3_SBAD = 3'd4;
    localparam logic [2:0] F3_JALR = 3'd0;

    typedef struct packed {
        logic [63:0] exec_pc;
        logic [63:0] next_pc;
        logic        wr;
        logic [4:0]  rd;
        logic [63:0] val;
        logic        taken;
        status_t     status;
    } retire_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         cfg_wen = 1'b0;
    logic [31:0]  cfg_wdata = '0;

    logic [63:0]  arch_regs [32];
    logic [63:0]  arch_pc;
    bit   [7:0]   mem_img [MEM_BYTES];
    logic [31:0]  data_base;
    retire_t      pending_retires [$];
    logic [31:0]  dir_instr [$];
    retire_t      dir_want [$];
    bit           dir_typed [$];
    bit           failed = 1'b0;
    bit           quiet = 1'b0;
    int unsigned  cycles = 0;

    rv64i_subset_execute_core #(.MEM_BYTES(MEM_BYTES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction
    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction
    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction
    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction
    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction
    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
        return {imm, rd, OP_LUI};
    endfunction

    // one row of the directed table
    function automatic void add_row(logic [31:0] ins, bit typed, retire_t want);
        dir_instr = {dir_instr, ins};
        dir_typed = {dir_typed, typed};
        dir_want = {dir_want, want};
    endfunction

    // architectural effect of one instruction
    function automatic retire_t execute_instr(logic [31:0] ins);
        retire_t     r;
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [63:0] a, b, opb, imm, npc, val, addr, off;
        logic        wr, taken, cond;
        status_t     st;
        int          n;
        op = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = arch_regs[ins[19:15]];
        b = arch_regs[ins[24:20]];
        npc = arch_pc + 64'd4;
        val = '0;
        wr = 1'b0;
        taken = 1'b0;
        st = ST_OK;
        imm = {{52{ins[31]}}, ins[31:20]};
        case (op)
            OP_R, OP_I: begin
                if (op == OP_R) begin
                    opb = b;
                    if (f7 != 0 && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
                        st = ST_UNSUP;
                end else begin
                    opb = imm;
                    if (f3 == F3_SLL && ins[31:26] != 0) st = ST_UNSUP;
                    if (f3 == F3_SR && ins[31:26] != 0 && ins[31:26] != F6_SRA) st = ST_UNSUP;
                end
                if (st == ST_OK) begin
                    case (f3)
                        F3_ADD: val = (op == OP_R && f7 == F7_ALT) ? a - opb : a + opb;
                        F3_SLL: val = a << opb[5:0];
                        F3_XOR: val = a ^ opb;
                        F3_SR:  val = ins[30] ? 64'($signed(a) >>> opb[5:0]) : a >> opb[5:0];
                        F3_OR:  val = a | opb;
                        F3_AND: val = a & opb;
                        default: st = ST_UNSUP;
                    endcase
                end
                wr = (st == ST_OK);
            end
            OP_LOAD: begin
                if (f3 == F3_LBAD) begin
                    st = ST_UNSUP;
                end else begin
                    n = 1 << f3[1:0];
                    addr = a + imm;
                    off = addr - {32'd0, data_base};
                    if (off >= 64'(MEM_BYTES) || 64'(n) > 64'(MEM_BYTES) - off) begin
                        st = ST_RANGE;
                    end else begin
                        for (int i = 0; i < n; i++)
                            val |= 64'(mem_img[int'(off) + i]) << (8 * i);
                        if (f3 < 3) begin
                            case (n)
                                1: val = {{56{val[7]}}, val[7:0]};
                                2: val = {{48{val[15]}}, val[15:0]};
                                default: val = {{32{val[31]}}, val[31:0]};
                            endcase
                        end
                        wr = 1'b1;
                    end
                end
            end
            OP_STORE: begin
                if (f3 > F3_SD) begin
                    st = ST_UNSUP;
                end else begin
                    n = 1 << f3;
                    addr = a + {{52{ins[31]}}, ins[31:25], ins[11:7]};
                    off = addr - {32'd0, data_base};
                    if (off >= 64'(MEM_BYTES) || 64'(n) > 64'(MEM_BYTES) - off)
                        st = ST_RANGE;
                    else
                        for (int i = 0; i < n; i++) mem_img[int'(off) + i] = b[8*i +: 8];
                end
            end
            OP_BRANCH: begin
                cond = 1'b0;
                case (f3)
                    F3_BEQ:  cond = (a == b);
                    F3_BNE:  cond = (a != b);
                    F3_BLT:  cond = ($signed(a) < $signed(b));
                    F3_BGE:  cond = ($signed(a) >= $signed(b));
                    F3_BLTU: cond = (a < b);
                    F3_BGEU: cond = (a >= b);
                    default: st = ST_UNSUP;
                endcase
                if (cond) begin
                    taken = 1'b1;
                    npc = arch_pc + {{52{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
                end
            end
            OP_JAL: begin
                val = arch_pc + 64'd4;
                wr = 1'b1;
                taken = 1'b1;
                npc = arch_pc + {{44{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
            end
            OP_JALR: begin
                if (f3 != F3_JALR) begin
                    st = ST_UNSUP;
                end else begin
                    val = arch_pc + 64'd4;
                    wr = 1'b1;
                    taken = 1'b1;
                    npc = (a + imm) & ~64'd1;
                end
            end
            OP_LUI: begin
                val = {{32{ins[31]}}, ins[31:12], 12'd0};
                wr = 1'b1;
            end
            default: st = ST_UNSUP;
        endcase
        if (rd == 0) wr = 1'b0;
        if (wr) arch_regs[rd] = val;
        else val = '0;
        r.exec_pc = arch_pc;
        r.next_pc = npc;
        r.wr = wr;
        r.rd = wr ? rd : 5'd0;
        r.val = val;
        r.taken = taken;
        r.status = st;
        arch_pc = npc;
        return r;
    endfunction

    task automatic send_instr(input logic [31:0] ins, input bit typed, input retire_t want);
        retire_t pred;
        s_tvalid <= 1'b1;
        s_tdata <= ins;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = execute_instr(ins);
        pending_retires = {pending_retires, (typed ? want : pred)};
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic send(input logic [31:0] ins);
        send_instr(ins, 1'b0, '0);
    endtask

    task automatic write_base(input logic [31:0] v);
        s_tvalid <= 1'b0;
        wait (pending_retires.size() == 0);
        repeat (8) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        data_base = v;
    endtask

    // zero-extended 32-bit pointer into rp (skipped one time in four), then a random load or store through it
    task automatic mem_access();
        logic [31:0] target;
        logic [11:0] lo;
        logic [31:0] hi;
        logic [4:0]  rp;
        logic [11:0] disp;
        if ($urandom_range(0, 7) == 0)
            target = data_base + MEM_BYTES - $urandom_range(0, 24);
        else
            target = data_base + $urandom_range(0, 256);
        rp = 5'($urandom_range(28, 31));
        lo = target[11:0];
        hi = target - {{20{lo[11]}}, lo};
        if ($urandom_range(0, 3) != 0) begin
            send(enc_u(hi[31:12], rp));
            send(enc_i(lo, rp, F3_ADD, rp, OP_I));
            send(enc_i(12'd32, rp, F3_SLL, rp, OP_I));
            send(enc_i(12'd32, rp, F3_SR, rp, OP_I));
        end
        disp = 12'($signed($urandom_range(0, 16)) - 8);
        if ($urandom_range(0, 1))
            send(enc_s(disp, 5'($urandom), rp, 3'($urandom_range(0, 3))));
        else
            send(enc_i(disp, rp, 3'($urandom_range(0, 6)), 5'($urandom), OP_LOAD));
    endtask

    task automatic random_instr();
        int pick;
        logic [2:0] f3;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            f3 = 3'($urandom);
            send(enc_r(($urandom_range(0, 1) && (f3 == F3_ADD || f3 == F3_SR)) ? F7_ALT :
                       ($urandom_range(0, 15) == 0 ? 7'($urandom) : 7'd0),
                       5'($urandom), 5'($urandom), f3, 5'($urandom), OP_R));
        end else if (pick < 50) begin
            f3 = 3'($urandom);
            if (f3 == F3_SR && $urandom_range(0, 1))
                send({F6_SRA, 26'($urandom)} & 32'hfc00_0f80 | {17'd0, F3_SR, 5'd0, OP_I}
                     | {6'd0, 6'($urandom), 5'($urandom), 15'd0});
            else
                send(enc_i(12'($urandom), 5'($urandom), f3, 5'($urandom), OP_I));
        end else if (pick < 72) begin
            mem_access();
        end else if (pick < 84) begin
            send(enc_b(13'($urandom), 5'($urandom), 5'($urandom), 3'($urandom)));
        end else if (pick < 88) begin
            send(enc_j(21'($urandom), 5'($urandom)));
        end else if (pick < 92) begin
            send(enc_i(12'($urandom), 5'($urandom), $urandom_range(0, 7) == 0 ? 3'($urandom) :
                       F3_JALR, 5'($urandom), OP_JALR));
        end else if (pick < 96) begin
            send(enc_u(20'($urandom), 5'($urandom)));
        end else begin
            send($urandom);
        end
    endtask

    // receiver back-pressure
    initial begin
        int run;
        forever begin
            m_tready <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge aclk);
            if (!quiet && $urandom_range(0, 1)) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        retire_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.exec_pc = m_tdata[63:0];
            got.next_pc = m_tdata[127:64];
            got.wr = m_tdata[128];
            got.rd = m_tdata[133:129];
            got.val = m_tdata[197:134];
            got.taken = m_tdata[198];
            got.status = status_t'(m_tdata[200:199]);
            if (pending_retires.size() == 0) begin
                $error("unexpected result transfer, exec_pc %h", got.exec_pc);
                failed = 1'b1;
            end else begin
                want = pending_retires.pop_front();
                if (got.exec_pc !== want.exec_pc) begin
                    $error("exec_pc expected %h actual %h", want.exec_pc, got.exec_pc);
                    failed = 1'b1;
                end
                if (got.next_pc !== want.next_pc) begin
                    $error("next_pc expected %h actual %h", want.next_pc, got.next_pc);
                    failed = 1'b1;
                end
                if (got.wr !== want.wr) begin
                    $error("reg_written expected %b actual %b", want.wr, got.wr);
                    failed = 1'b1;
                end
                if (got.rd !== want.rd) begin
                    $error("reg_index expected %0d actual %0d", want.rd, got.rd);
                    failed = 1'b1;
                end
                if (got.val !== want.val) begin
                    $error("reg_value expected %h actual %h", want.val, got.val);
                    failed = 1'b1;
                end
                if (got.taken !== want.taken) begin
                    $error("branch_taken expected %b actual %b", want.taken, got.taken);
                    failed = 1'b1;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        logic [31:0] bases [5];
        int          counts [5];

        for (int i = 0; i < 32; i++) arch_regs[i] = '0;
        arch_pc = '0;
        data_base = MEM_BASE_RST;

        // rows with a typed expectation first, from the reset state
        add_row(enc_i(12'hfff, 5'd0, F3_ADD, 5'd1, OP_I), 1'b1,
                '{64'd0, 64'd4, 1'b1, 5'd1, {64{1'b1}}, 1'b0, ST_OK});
        add_row(32'h0000_0000, 1'b1,
                '{64'd4, 64'd8, 1'b0, 5'd0, 64'd0, 1'b0, ST_UNSUP});
        add_row(enc_u(20'h80000, 5'd2), 1'b1,
                '{64'd8, 64'd12, 1'b1, 5'd2, 64'hffff_ffff_8000_0000, 1'b0, ST_OK});
        add_row(enc_i(12'd2047, 5'd0, F3_ADD, 5'd3, OP_I), 1'b0, '0);
        add_row(enc_r(7'd0, 5'd3, 5'd1, F3_ADD, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(F7_ALT, 5'd1, 5'd3, F3_ADD, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(7'd0, 5'd3, 5'd1, F3_AND, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(7'd0, 5'd3, 5'd2, F3_OR, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(7'd0, 5'd3, 5'd1, F3_XOR, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(7'd0, 5'd3, 5'd1, F3_SLL, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(7'd0, 5'd3, 5'd2, F3_SR, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(F7_ALT, 5'd3, 5'd2, F3_SR, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_i(12'h800, 5'd1, F3_XOR, 5'd10, OP_I), 1'b0, '0);
        add_row(enc_i(12'h800, 5'd3, F3_OR, 5'd10, OP_I), 1'b0, '0);
        add_row(enc_i(12'h7ff, 5'd2, F3_AND, 5'd10, OP_I), 1'b0, '0);
        add_row(enc_i(12'd63, 5'd1, F3_SLL, 5'd11, OP_I), 1'b0, '0);
        add_row(enc_i(12'd63, 5'd1, F3_SR, 5'd12, OP_I), 1'b0, '0);
        add_row(enc_i({F6_SRA, 6'd63}, 5'd2, F3_SR, 5'd13, OP_I), 1'b0, '0);
        // unsupported encodings
        add_row(enc_r(7'd0, 5'd3, 5'd1, F3_SLT, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_r(7'd1, 5'd3, 5'd1, F3_ADD, 5'd4, OP_R), 1'b0, '0);
        add_row(enc_i({6'h11, 6'd1}, 5'd2, F3_SR, 5'd13, OP_I), 1'b0, '0);
        add_row(enc_i(12'd0, 5'd5, F3_LBAD, 5'd6, OP_LOAD), 1'b0, '0);
        add_row(enc_s(12'd0, 5'd1, 5'd5, F3_SBAD), 1'b0, '0);
        add_row(enc_b(13'd8, 5'd0, 5'd0, F3_BBAD), 1'b0, '0);
        add_row(enc_i(12'd0, 5'd1, 3'd1, 5'd31, OP_JALR), 1'b0, '0);
        // misaligned memory traffic at the base, then the top edge
        add_row(enc_u(20'h00010, 5'd5), 1'b0, '0);
        add_row(enc_s(12'd3, 5'd2, 5'd5, F3_SD), 1'b0, '0);
        add_row(enc_i(12'd3, 5'd5, F3_LD, 5'd6, OP_LOAD), 1'b0, '0);
        add_row(enc_i(12'd7, 5'd5, F3_LB, 5'd7, OP_LOAD), 1'b0, '0);
        add_row(enc_i(12'd9, 5'd5, F3_LWU, 5'd8, OP_LOAD), 1'b0, '0);
        add_row(enc_i(12'd3, 5'd5, F3_LW, 5'd0, OP_LOAD), 1'b0, '0);
        add_row(enc_u(20'h00050, 5'd9), 1'b0, '0);
        add_row(enc_i(12'hffc, 5'd9, F3_LD, 5'd8, OP_LOAD), 1'b0, '0);
        add_row(enc_i(12'hffc, 5'd9, F3_LHU, 5'd8, OP_LOAD), 1'b0, '0);
        add_row(enc_s(12'd0, 5'd1, 5'd0, F3_SB), 1'b0, '0);
        // control flow
        add_row(enc_b(13'd8, 5'd0, 5'd0, F3_BEQ), 1'b0, '0);
        add_row(enc_b(13'h1000, 5'd1, 5'd0, F3_BLT), 1'b0, '0);
        add_row(enc_b(13'hffc, 5'd1, 5'd0, F3_BLTU), 1'b0, '0);
        add_row(enc_j(21'h100000, 5'd1), 1'b0, '0);
        add_row(enc_i(12'hfff, 5'd1, F3_JALR, 5'd31, OP_JALR), 1'b0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_base(MEM_BASE_RST);
        foreach (dir_instr[i]) send_instr(dir_instr[i], dir_typed[i], dir_want[i]);

        bases = '{MEM_BASE_RST, 32'd0, 32'hffff_ffff, 32'hfffc_0000, 32'($urandom)};
        counts = '{180, 180, 120, 180, 240};
        foreach (bases[p]) begin
            if (p != 0) write_base(bases[p]);
            if (p == 4) quiet = 1'b1;
            for (int k = 0; k < counts[p]; k++) random_instr();
        end
        s_tvalid <= 1'b0;
        wait (pending_retires.size() == 0);
        repeat (20) @(posedge aclk);
        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
